@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every clock edge outside reset
`define UVST_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("%m: assertion failed");

// antecedent implies consequent in the same cycle
`define UVST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`else

`define UVST_ASSERT(lbl, clk, rstn, cond)
`define UVST_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/uvst_pkg.sv @@
// shared types and constants of the uv sphere cell tessellator
`default_nettype none

package uvst_pkg;

  localparam int MAX_LINES       = 1024;
  localparam int MIN_LINES       = 3;
  localparam int COORD_FRAC_BITS = 14;

  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int LINE_IDX_W = $clog2(MAX_LINES);
  localparam int FIELD_W    = 16;

  // phase in turns, q0.32
  localparam int PHASE_W   = 32;
  localparam int TEX_FRAC  = 15;
  // sine values in q30
  localparam int SINE_FRAC = 30;
  localparam int SINE_W    = 32;
  localparam int MAG_W     = 31;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int COORD_SHIFT = 2 * SINE_FRAC - COORD_FRAC_BITS;
  localparam int COORD_ONE   = 1 << COORD_FRAC_BITS;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << SINE_FRAC;

  // odd taylor coefficients of sin(pi/2 u), highest order first
  localparam logic [MAG_W-1:0] SIN_COEF [0:5] = '{
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598676, 31'd1686629713
  };

  typedef enum logic [0:0] {
    CFG_LONGITUDE_COUNT = 1'b0,
    CFG_LATITUDE_COUNT  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [INDEX_W-1:0] row_index;
    logic [INDEX_W-1:0] column_index;
  } in_word_t;

  typedef struct packed {
    logic                      triangle_select;
    logic [1:0]                corner;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic [FIELD_W-1:0]        tex_s;
    logic [FIELD_W-1:0]        tex_t;
    logic                      last_vertex;
  } out_word_t;

  // one row or column entry of the angle tables
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [FIELD_W-1:0] tex;
  } tab_entry_t;

  typedef struct packed {
    logic                  ready;
    logic [LINE_IDX_W-1:0] lon_span;
    logic [LINE_IDX_W-1:0] lat_span;
  } tab_status_t;

endpackage

`default_nettype wire

@@ rtl/uvst_sine.sv @@
// pipelined sine of a phase in turns, q30 result, eight stages
`default_nettype none

module uvst_sine import uvst_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [PHASE_W-1:0]       phase,
  output logic signed [SINE_W-1:0] sine
);

  logic [MAG_W-1:0]         u_r   [1:7];
  logic                     neg_r [1:7];
  logic [MAG_W-1:0]         z_r   [2:6];
  logic [MAG_W-1:0]         t_r   [3:7];
  logic signed [SINE_W-1:0] sine_r;

  logic [MAG_W-1:0]         u_nxt;
  logic [PROD_W-1:0]        sq;
  logic [MAG_W-1:0]         z_nxt;
  logic [PROD_W-1:0]        hp    [3:7];
  logic [MAG_W-1:0]         t_nxt [3:7];
  logic [PROD_W-1:0]        mp;
  logic [SINE_W-1:0]        m;
  logic signed [SINE_W-1:0] sine_nxt;

  always_comb begin
    // fold the phase into the first quarter wave
    u_nxt = phase[SINE_FRAC] ? (MAG_W'(QUARTER_TURN) - MAG_W'(phase[SINE_FRAC-1:0]))
                             : MAG_W'(phase[SINE_FRAC-1:0]);
    sq    = u_r[1] * u_r[1];
    z_nxt = sq[SINE_FRAC+MAG_W-1:SINE_FRAC];
    // horner steps, one per stage
    hp[3]    = z_r[2] * SIN_COEF[0];
    t_nxt[3] = SIN_COEF[1] - hp[3][SINE_FRAC+MAG_W-1:SINE_FRAC];
    for (int s = 4; s <= 7; s++) begin
      hp[s]    = z_r[s-1] * t_r[s-1];
      t_nxt[s] = SIN_COEF[s-2] - hp[s][SINE_FRAC+MAG_W-1:SINE_FRAC];
    end
    mp       = u_r[7] * t_r[7];
    m        = SINE_W'(mp[SINE_FRAC+MAG_W-1:SINE_FRAC]);
    sine_nxt = neg_r[7] ? -$signed(m) : $signed(m);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[1]   <= u_nxt;
      neg_r[1] <= phase[PHASE_W-1];
      for (int i = 2; i <= 7; i++) begin
        u_r[i]   <= u_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
      z_r[2] <= z_nxt;
      for (int i = 3; i <= 6; i++) begin
        z_r[i] <= z_r[i-1];
      end
      for (int s = 3; s <= 7; s++) begin
        t_r[s] <= t_nxt[s];
      end
      sine_r <= sine_nxt;
    end
  end

  assign sine = sine_r;

endmodule

`default_nettype wire

@@ rtl/uvst_table.sv @@
// config registers and per-row / per-column angle and texture tables
`default_nettype none

module uvst_table import uvst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [COUNT_W-1:0]    cfg_data,
  input  logic                  rd_en,
  input  logic [LINE_IDX_W-1:0] rd_row,
  input  logic [LINE_IDX_W-1:0] rd_col,
  output tab_entry_t            row_rd,
  output tab_entry_t            col_rd,
  output tab_status_t           status
);

  typedef enum logic [1:0] {ST_DIV, ST_SWEEP, ST_READY} state_t;

  typedef struct packed {
    logic [LINE_IDX_W-1:0] rem;
    logic [PHASE_W-1:0]    q;
  } lane_t;

  state_t                state_r;
  logic [COUNT_W-1:0]    lon_count_r, lat_count_r;
  logic [5:0]            div_k_r;
  logic [5:0]            div_k_nxt;
  lane_t                 lon_div_r, lat_div_r, lon_div_nxt, lat_div_nxt;
  lane_t                 lon_tex_step_r, lon_ph_step_r, lat_tex_step_r, lat_ph_step_r;
  lane_t                 az_acc_r, ts_acc_r, el_acc_r, tt_acc_r;
  logic [LINE_IDX_W:0]   sw_n_r;
  logic [LINE_IDX_W-1:0] lon_span, lat_span;
  lane_t                 lane_init;

  tab_entry_t row_mem [MAX_LINES];
  tab_entry_t col_mem [MAX_LINES];
  tab_entry_t row_rd_r, col_rd_r;

  function automatic logic [LINE_IDX_W-1:0] span_of(input logic [COUNT_W-1:0] cnt);
    if (int'(cnt) < MIN_LINES) return LINE_IDX_W'(MIN_LINES - 1);
    else if (int'(cnt) > MAX_LINES) return LINE_IDX_W'(MAX_LINES - 1);
    else return LINE_IDX_W'(cnt - COUNT_W'(1));
  endfunction

  // one restoring step of 2^k / span
  function automatic lane_t div_step(input lane_t l, input logic [LINE_IDX_W-1:0] span);
    logic [LINE_IDX_W:0] rem2;
    logic                ge;
    lane_t               o;
    rem2  = {l.rem, 1'b0};
    ge    = rem2 >= {1'b0, span};
    o.rem = ge ? LINE_IDX_W'(rem2 - {1'b0, span}) : LINE_IDX_W'(rem2);
    o.q   = {l.q[PHASE_W-2:0], ge};
    return o;
  endfunction

  // advance a rounded quotient by one step of the numerator
  function automatic lane_t acc_step(input lane_t a, input lane_t st,
                                     input logic [LINE_IDX_W-1:0] span);
    logic [LINE_IDX_W:0] s;
    logic                ge;
    lane_t               o;
    s     = {1'b0, a.rem} + {1'b0, st.rem};
    ge    = s >= {1'b0, span};
    o.rem = ge ? LINE_IDX_W'(s - {1'b0, span}) : LINE_IDX_W'(s);
    o.q   = a.q + st.q + PHASE_W'(ge);
    return o;
  endfunction

  assign lon_span    = span_of(lon_count_r);
  assign lat_span    = span_of(lat_count_r);
  assign div_k_nxt   = div_k_r + 6'd1;
  assign lon_div_nxt = div_step(lon_div_r, lon_span);
  assign lat_div_nxt = div_step(lat_div_r, lat_span);
  assign lane_init   = '{rem: LINE_IDX_W'(1), q: '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_DIV;
      lon_count_r <= COUNT_W'(MIN_LINES);
      lat_count_r <= COUNT_W'(MIN_LINES);
      div_k_r     <= '0;
      lon_div_r   <= lane_init;
      lat_div_r   <= lane_init;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONGITUDE_COUNT: lon_count_r <= cfg_data;
        CFG_LATITUDE_COUNT:  lat_count_r <= cfg_data;
      endcase
      state_r   <= ST_DIV;
      div_k_r   <= '0;
      lon_div_r <= lane_init;
      lat_div_r <= lane_init;
    end else begin
      unique case (state_r)
        ST_DIV: begin
          div_k_r   <= div_k_nxt;
          lon_div_r <= lon_div_nxt;
          lat_div_r <= lat_div_nxt;
          if (int'(div_k_nxt) == TEX_FRAC) begin
            lon_tex_step_r <= lon_div_nxt;
            lat_tex_step_r <= lat_div_nxt;
          end
          if (int'(div_k_nxt) == PHASE_W - 1) begin
            lat_ph_step_r <= lat_div_nxt;
          end
          if (int'(div_k_nxt) == PHASE_W) begin
            lon_ph_step_r <= lon_div_nxt;
            state_r       <= ST_SWEEP;
            sw_n_r        <= '0;
            az_acc_r      <= '{rem: lon_span >> 1, q: '0};
            ts_acc_r      <= '{rem: lon_span >> 1, q: '0};
            el_acc_r      <= '{rem: lat_span >> 1, q: '0};
            tt_acc_r      <= '{rem: lat_span >> 1, q: '0};
          end
        end
        ST_SWEEP: begin
          az_acc_r <= acc_step(az_acc_r, lon_ph_step_r, lon_span);
          ts_acc_r <= acc_step(ts_acc_r, lon_tex_step_r, lon_span);
          el_acc_r <= acc_step(el_acc_r, lat_ph_step_r, lat_span);
          tt_acc_r <= acc_step(tt_acc_r, lat_tex_step_r, lat_span);
          sw_n_r   <= sw_n_r + 1'b1;
          if (int'(sw_n_r) == MAX_LINES - 1) begin
            state_r <= ST_READY;
          end
        end
        ST_READY: begin
          state_r <= ST_READY;
        end
        default: state_r <= ST_DIV;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP) begin
      row_mem[sw_n_r[LINE_IDX_W-1:0]] <= '{phase: el_acc_r.q, tex: FIELD_W'(tt_acc_r.q)};
      col_mem[sw_n_r[LINE_IDX_W-1:0]] <= '{phase: az_acc_r.q, tex: FIELD_W'(ts_acc_r.q)};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_rd_r <= row_mem[rd_row];
      col_rd_r <= col_mem[rd_col];
    end
  end

  assign row_rd          = row_rd_r;
  assign col_rd          = col_rd_r;
  assign status.ready    = (state_r == ST_READY);
  assign status.lon_span = lon_span;
  assign status.lat_span = lat_span;

endmodule

`default_nettype wire

@@ rtl/uv_sphere_cell_tessellator.sv @@
// top level of the uv sphere cell tessellator
// usage:
//   in channel (in_valid/in_stall/in_data) takes one grid cell word: row and column.
//   out channel (out_valid/out_stall/out_data) gives six vertex words per cell,
//   triangle 0 corners 0,1,2 then triangle 1; last_vertex marks the sixth word.
//   cfg port writes longitude_count (index 0) and latitude_count (index 1).
// throughput: set by the single vertex issue slot of the cell sequencer, which may take a
//   new cell on the final slot of the previous one; the vertex pipeline takes a new vertex
//   every cycle unless the out channel stalls. The first vertex word of a cell passes the
//   sequencer, table read, 8-stage sine unit, product and rounding/output registers.
// reset and config writes rebuild the angle tables: a divider pass and then a fill of the
//   row and column tables, with in_stall high throughout.
// a stall on the out channel freezes the whole pipeline; the output register holds
//   its word and the input side stalls until the pipeline can move again.
`default_nettype none
`include "assert_macros.svh"

module uv_sphere_cell_tessellator import uvst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_index_t         cfg_index,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data
);

  localparam int          VERTS     = 6;
  localparam int          SINE_LAT  = 8;
  localparam logic [2:0]  VERT_LAST = 3'(VERTS - 1);

  typedef struct packed {
    logic       tri_sel;
    logic [1:0] corner;
    logic       last;
  } vmeta_t;

  typedef struct packed {
    logic   row_inc;
    logic   col_inc;
    vmeta_t meta;
  } vsel_t;

  typedef struct packed {
    logic               valid;
    vmeta_t             meta;
    logic [FIELD_W-1:0] tex_s;
    logic [FIELD_W-1:0] tex_t;
  } line_t;

  // corner order 0,1,2 then 0,2,3; corner 1 and 2 step the column, 2 and 3 the row
  function automatic vsel_t vert_of(input logic [2:0] k);
    vsel_t v;
    v = '0;
    unique case (k)
      3'd0: v = '{row_inc: 1'b0, col_inc: 1'b0, meta: '{1'b0, 2'd0, 1'b0}};
      3'd1: v = '{row_inc: 1'b0, col_inc: 1'b1, meta: '{1'b0, 2'd1, 1'b0}};
      3'd2: v = '{row_inc: 1'b1, col_inc: 1'b1, meta: '{1'b0, 2'd2, 1'b0}};
      3'd3: v = '{row_inc: 1'b0, col_inc: 1'b0, meta: '{1'b1, 2'd0, 1'b0}};
      3'd4: v = '{row_inc: 1'b1, col_inc: 1'b1, meta: '{1'b1, 2'd1, 1'b0}};
      3'd5: v = '{row_inc: 1'b1, col_inc: 1'b0, meta: '{1'b1, 2'd2, 1'b1}};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [SINE_W-1:0] v);
    logic [SINE_W-1:0] a;
    a = v[SINE_W-1] ? SINE_W'(-v) : SINE_W'(v);
    return a[MAG_W-1:0];
  endfunction

  // round half away from zero, saturate magnitude to one, apply sign
  function automatic logic [FIELD_W-1:0] to_coord(input logic [PROD_W-1:0] p,
                                                  input logic neg);
    logic [PROD_W:0]    sum;
    logic [PROD_W:0]    rsh;
    logic [FIELD_W-1:0] m;
    sum = {1'b0, p} + ((PROD_W+1)'(1) << (COORD_SHIFT - 1));
    rsh = sum >> COORD_SHIFT;
    m   = (rsh > (PROD_W+1)'(COORD_ONE)) ? FIELD_W'(COORD_ONE) : rsh[FIELD_W-1:0];
    return neg ? -m : m;
  endfunction

  // global advance: the pipeline moves unless the output word is held
  logic adv;

  tab_status_t tab_st;
  tab_entry_t  row_rd, col_rd;

  // cell sequencer
  logic                  seq_busy_r;
  logic [2:0]            seq_k_r;
  logic [INDEX_W-1:0]    seq_row_r, seq_col_r;
  logic                  seq_last;
  logic                  in_acc;
  logic [INDEX_W-1:0]    row_max, col_max, row_cl, col_cl;
  vsel_t                 vs;

  // vertex stages
  logic                  a_valid_r;
  logic [LINE_IDX_W-1:0] a_row_r, a_col_r;
  vmeta_t                a_meta_r;
  logic                  b_valid_r;
  vmeta_t                b_meta_r;
  line_t                 line_r [0:SINE_LAT-1];

  logic [PHASE_W-1:0]       el_ph, el_ph_c, az_ph, az_ph_c;
  logic signed [SINE_W-1:0] sin_el, cos_el, sin_az, cos_az;

  logic                  d_valid_r;
  vmeta_t                d_meta_r;
  logic [FIELD_W-1:0]    d_ts_r, d_tt_r;
  logic [PROD_W-1:0]     d_px_r, d_py_r, d_pz_r;
  logic                  d_nx_r, d_ny_r, d_nz_r;

  logic                  out_valid_r;
  out_word_t             out_data_r;

  assign adv      = !out_valid_r || !out_stall;
  assign seq_last = (seq_k_r == VERT_LAST);
  assign in_stall = !tab_st.ready || !adv || (seq_busy_r && !seq_last);
  assign in_acc   = in_valid && !in_stall;

  // index beyond the last cell saturates to the last cell
  assign row_max = INDEX_W'(tab_st.lat_span - 1'b1);
  assign col_max = INDEX_W'(tab_st.lon_span - 1'b1);
  assign row_cl  = (in_data.row_index > row_max) ? row_max : in_data.row_index;
  assign col_cl  = (in_data.column_index > col_max) ? col_max : in_data.column_index;
  assign vs      = vert_of(seq_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_busy_r <= 1'b0;
      seq_k_r    <= '0;
      a_valid_r  <= 1'b0;
    end else if (adv) begin
      a_valid_r <= seq_busy_r;
      if (seq_busy_r) begin
        a_row_r  <= LINE_IDX_W'(seq_row_r) + LINE_IDX_W'(vs.row_inc);
        a_col_r  <= LINE_IDX_W'(seq_col_r) + LINE_IDX_W'(vs.col_inc);
        a_meta_r <= vs.meta;
      end
      // a new cell may start on the final vertex slot of the previous one
      if (in_acc) begin
        seq_busy_r <= 1'b1;
        seq_k_r    <= '0;
        seq_row_r  <= row_cl;
        seq_col_r  <= col_cl;
      end else if (seq_busy_r) begin
        seq_k_r <= seq_k_r + 3'd1;
        if (seq_last) begin
          seq_busy_r <= 1'b0;
        end
      end
    end
  end

  uvst_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_en     (adv),
    .rd_row    (a_row_r),
    .rd_col    (a_col_r),
    .row_rd    (row_rd),
    .col_rd    (col_rd),
    .status    (tab_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
      b_meta_r  <= a_meta_r;
    end
  end

  // cosine is the sine a quarter turn ahead
  assign el_ph   = row_rd.phase;
  assign el_ph_c = row_rd.phase + QUARTER_TURN;
  assign az_ph   = col_rd.phase;
  assign az_ph_c = col_rd.phase + QUARTER_TURN;

  uvst_sine u_sin_el (.clk(clk), .en(adv), .phase(el_ph),   .sine(sin_el));
  uvst_sine u_cos_el (.clk(clk), .en(adv), .phase(el_ph_c), .sine(cos_el));
  uvst_sine u_sin_az (.clk(clk), .en(adv), .phase(az_ph),   .sine(sin_az));
  uvst_sine u_cos_az (.clk(clk), .en(adv), .phase(az_ph_c), .sine(cos_az));

  // sideband delay line matching the sine unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SINE_LAT; i++) begin
        line_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      line_r[0] <= '{valid: b_valid_r, meta: b_meta_r, tex_s: col_rd.tex, tex_t: row_rd.tex};
      for (int i = 1; i < SINE_LAT; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  // products: x = sin(el)*cos(az), y = -cos(el)*1, z = -sin(el)*sin(az), kept as sign and magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= line_r[SINE_LAT-1].valid;
      d_meta_r  <= line_r[SINE_LAT-1].meta;
      d_ts_r    <= line_r[SINE_LAT-1].tex_s;
      d_tt_r    <= line_r[SINE_LAT-1].tex_t;
      d_px_r    <= mag_of(sin_el) * mag_of(cos_az);
      d_py_r    <= PROD_W'({mag_of(cos_el), SINE_FRAC'(0)});
      d_pz_r    <= mag_of(sin_el) * mag_of(sin_az);
      d_nx_r    <= sin_el[SINE_W-1] != cos_az[SINE_W-1];
      d_ny_r    <= !cos_el[SINE_W-1] && (cos_el != '0);
      d_nz_r    <= (!sin_el[SINE_W-1] && (sin_el != '0)) != sin_az[SINE_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r                <= d_valid_r;
      out_data_r.triangle_select <= d_meta_r.tri_sel;
      out_data_r.corner          <= d_meta_r.corner;
      out_data_r.pos_x           <= to_coord(d_px_r, d_nx_r);
      out_data_r.pos_y           <= to_coord(d_py_r, d_ny_r);
      out_data_r.pos_z           <= to_coord(d_pz_r, d_nz_r);
      out_data_r.tex_s           <= d_ts_r;
      out_data_r.tex_t           <= d_tt_r;
      out_data_r.last_vertex     <= d_meta_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a cell is taken only once the tables are built
  `UVST_ASSERT_IMPL(a_acc_ready, clk, rst_n, in_valid && !in_stall, tab_st.ready)
  // a new cell overlaps the previous one only on its final vertex slot
  `UVST_ASSERT_IMPL(a_seq_overlap, clk, rst_n, in_valid && !in_stall && seq_busy_r,
                    seq_k_r == VERT_LAST)
  // saturation keeps every coordinate within plus or minus one; the check covers pos_x
  `UVST_ASSERT_IMPL(a_coord_range, clk, rst_n, out_valid_r,
                    ($signed(out_data_r.pos_x) <= COORD_ONE) &&
                    ($signed(out_data_r.pos_x) >= -COORD_ONE))

endmodule

`default_nettype wire
